// File: rtl/cuqm_pkg.sv
package cuqm_pkg;

  localparam int unsigned SampleBits = 16;
  localparam int unsigned LineBits   = 10;
  localparam int unsigned PhaseBits  = 32;
  localparam int unsigned TableDepth = 1024;
  localparam int unsigned TableBits  = $clog2(TableDepth);
  // One octant of the circle, folded: entries 0 .. OctSize
  localparam int unsigned OctSize    = TableDepth / 8;
  localparam int unsigned MagBits    = TableBits - 2;

  localparam logic [PhaseBits-1:0] PhaseStepReset = 32'd884951949;

  localparam longint unsigned Q30One   = 64'd1073741824;
  localparam longint unsigned TwoPiQ30 = 64'd6746518852;
  localparam int unsigned     QSh      = 31 - SampleBits;
  localparam longint unsigned TabCap   = (64'd1 << (SampleBits - 1)) - 64'd1;

  typedef enum logic {
    OpDown = 1'b0,
    OpUp   = 1'b1
  } op_e;

  typedef struct packed {
    op_e                          opcode;
    logic signed [SampleBits-1:0] in_i;
    logic signed [SampleBits-1:0] in_q;
    logic [LineBits-1:0]          line_number;
    logic                         line_end;
  } in_item_t;

  typedef struct packed {
    logic signed [SampleBits-1:0] out_i;
    logic signed [SampleBits-1:0] out_q;
    logic                         out_line_end;
  } out_item_t;

  // Stage 2 to stage 3: four products plus the post-rotation amount and the line end
  typedef struct packed {
    logic signed [2*SampleBits:0] p_xc;
    logic signed [2*SampleBits:0] p_ys;
    logic signed [2*SampleBits:0] p_xs;
    logic signed [2*SampleBits:0] p_yc;
    logic [1:0]                   rot_k;
    logic                         line_end;
  } prod_t;

  typedef logic [OctSize:0][SampleBits-2:0] mag_tab_t;

  function automatic logic [SampleBits-2:0] q30_to_tab(longint unsigned v);
    longint unsigned r;
    r = (v + (64'd1 << (QSh - 1))) >> QSh;
    if (r > TabCap) begin
      r = TabCap;
    end
    return r[SampleBits-2:0];
  endfunction

  // Residual angle of table step m, in radians Q30
  function automatic longint unsigned osc_x(int unsigned m);
    longint unsigned ang;
    ang = longint'(m) << (PhaseBits - TableBits);
    return (ang * TwoPiQ30) >> 32;
  endfunction

  function automatic logic [SampleBits-2:0] sin_mag(int unsigned m);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    x  = osc_x(m);
    x2 = (x * x) >> 30;
    t  = Q30One - x2 / 72;
    t  = Q30One - ((x2 * t) >> 30) / 42;
    t  = Q30One - ((x2 * t) >> 30) / 20;
    t  = Q30One - ((x2 * t) >> 30) / 6;
    return q30_to_tab((x * t) >> 30);
  endfunction

  function automatic logic [SampleBits-2:0] cos_mag(int unsigned m);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    x  = osc_x(m);
    x2 = (x * x) >> 30;
    t  = Q30One - x2 / 90;
    t  = Q30One - ((x2 * t) >> 30) / 56;
    t  = Q30One - ((x2 * t) >> 30) / 30;
    t  = Q30One - ((x2 * t) >> 30) / 12;
    t  = Q30One - ((x2 * t) >> 30) / 2;
    return q30_to_tab(t);
  endfunction

  function automatic mag_tab_t build_sin_tab();
    mag_tab_t tab;
    for (int unsigned m = 0; m <= OctSize; m++) begin
      tab[m] = sin_mag(m);
    end
    return tab;
  endfunction

  function automatic mag_tab_t build_cos_tab();
    mag_tab_t tab;
    for (int unsigned m = 0; m <= OctSize; m++) begin
      tab[m] = cos_mag(m);
    end
    return tab;
  endfunction

  localparam mag_tab_t SinTab = build_sin_tab();
  localparam mag_tab_t CosTab = build_cos_tab();

endpackage

// File: rtl/cuqm_nco.sv
module cuqm_nco import cuqm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [PhaseBits-1:0] cfg_wdata_i,
  input  logic                 take_i,
  input  op_e                  op_i,
  output logic [TableBits-1:0] index_o
);

  logic [PhaseBits-1:0] step_q;
  logic [PhaseBits-1:0] down_acc_q, down_acc_d;
  logic [PhaseBits-1:0] up_acc_q, up_acc_d;

  // Table index comes from the phase before it advances
  assign index_o = (op_i == OpUp) ? up_acc_q[PhaseBits-1 -: TableBits]
                                  : down_acc_q[PhaseBits-1 -: TableBits];

  always_comb begin
    down_acc_d = down_acc_q;
    up_acc_d   = up_acc_q;
    if (take_i) begin
      if (op_i == OpUp) begin
        up_acc_d = up_acc_q + step_q;
      end else begin
        down_acc_d = down_acc_q + step_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q     <= PhaseStepReset;
      down_acc_q <= '0;
      up_acc_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        step_q <= cfg_wdata_i;
      end
      down_acc_q <= down_acc_d;
      up_acc_q   <= up_acc_d;
    end
  end

endmodule

// File: rtl/cuqm_osc.sv
module cuqm_osc import cuqm_pkg::*; (
  input  logic [TableBits-1:0]         index_i,
  output logic signed [SampleBits-1:0] cos_o,
  output logic signed [SampleBits-1:0] sin_o
);

  logic [TableBits-1:0]  shifted;
  logic [1:0]            quad;
  logic [TableBits-3:0]  low;
  logic                  neg;
  logic [MagBits-1:0]    mag;
  logic signed [SampleBits-1:0] c;
  logic signed [SampleBits-1:0] s_pos;
  logic signed [SampleBits-1:0] s;

  // Fold into a quadrant and a residual of at most one octant either way
  assign shifted = index_i + TableBits'(OctSize);
  assign quad    = shifted[TableBits-1 -: 2];
  assign low     = shifted[TableBits-3:0];
  assign neg     = low < MagBits'(OctSize);
  assign mag     = neg ? MagBits'(OctSize) - low : low - MagBits'(OctSize);

  assign c     = $signed({1'b0, CosTab[mag]});
  assign s_pos = $signed({1'b0, SinTab[mag]});
  assign s     = neg ? -s_pos : s_pos;

  always_comb begin
    case (quad)
      2'd0: begin
        cos_o = c;
        sin_o = s;
      end
      2'd1: begin
        cos_o = -s;
        sin_o = c;
      end
      2'd2: begin
        cos_o = -c;
        sin_o = -s;
      end
      default: begin
        cos_o = s;
        sin_o = -c;
      end
    endcase
  end

endmodule

// File: rtl/cuqm_mix.sv
module cuqm_mix import cuqm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 load_i,
  input  in_item_t             item_i,
  input  logic [TableBits-1:0] index_i,
  output prod_t                prod_o
);

  logic signed [SampleBits-1:0] co;
  logic signed [SampleBits-1:0] si;
  logic signed [SampleBits-1:0] s_eff;
  logic signed [SampleBits:0]   xi;
  logic signed [SampleBits:0]   xq;
  logic signed [SampleBits:0]   xr_i;
  logic signed [SampleBits:0]   xr_q;
  logic [1:0]                   k;
  prod_t                        prod_d;
  prod_t                        prod_q;

  cuqm_osc u_osc (
    .index_i (index_i),
    .cos_o   (co),
    .sin_o   (si)
  );

  assign k     = item_i.line_number[2:1];
  assign xi    = (SampleBits + 1)'(item_i.in_i);
  assign xq    = (SampleBits + 1)'(item_i.in_q);
  // Downconvert mixes with the conjugate
  assign s_eff = (item_i.opcode == OpDown) ? -si : si;

  // Downconvert rotates the input before mixing
  always_comb begin
    xr_i = xi;
    xr_q = xq;
    if (item_i.opcode == OpDown) begin
      case (k)
        2'd0: begin
          xr_i = xi;
          xr_q = xq;
        end
        2'd1: begin
          xr_i = -xq;
          xr_q = xi;
        end
        2'd2: begin
          xr_i = -xi;
          xr_q = -xq;
        end
        default: begin
          xr_i = xq;
          xr_q = -xi;
        end
      endcase
    end
  end

  always_comb begin
    prod_d.p_xc     = xr_i * co;
    prod_d.p_ys     = xr_q * s_eff;
    prod_d.p_xs     = xr_i * s_eff;
    prod_d.p_yc     = xr_q * co;
    // Upconvert rotates back by minus k quarter turns afterwards
    prod_d.rot_k    = (item_i.opcode == OpUp) ? 2'd0 - k : 2'd0;
    prod_d.line_end = item_i.line_end;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

// File: rtl/cuqm_narrow.sv
module cuqm_narrow import cuqm_pkg::*; (
  input  logic      clk_i,
  input  logic      load_i,
  input  prod_t     prod_i,
  output out_item_t item_o
);

  localparam int unsigned PW = 2 * SampleBits + 1;
  localparam int unsigned RW = PW + 2;

  logic signed [PW:0]   yi;
  logic signed [PW:0]   yq;
  logic signed [RW-1:0] ei;
  logic signed [RW-1:0] eq;
  logic signed [RW-1:0] ri;
  logic signed [RW-1:0] rq;
  out_item_t            item_d;
  out_item_t            item_q;

  // Round half up from Q30 to Q15, then clamp
  function automatic logic signed [SampleBits-1:0] narrow(logic signed [RW-1:0] v);
    logic signed [RW-1:0] r;
    logic signed [RW-1:0] hi;
    logic signed [RW-1:0] lo;
    hi = RW'((64'sd1 <<< (SampleBits - 1)) - 64'sd1);
    lo = -hi - RW'(1);
    r  = (v + RW'(64'sd1 <<< (SampleBits - 2))) >>> (SampleBits - 1);
    if (r > hi) begin
      r = hi;
    end else if (r < lo) begin
      r = lo;
    end
    return r[SampleBits-1:0];
  endfunction

  assign yi = (PW + 1)'(prod_i.p_xc) - (PW + 1)'(prod_i.p_ys);
  assign yq = (PW + 1)'(prod_i.p_xs) + (PW + 1)'(prod_i.p_yc);

  always_comb begin
    ei = RW'(yi);
    eq = RW'(yq);
    case (prod_i.rot_k)
      2'd0: begin
        ri = ei;
        rq = eq;
      end
      2'd1: begin
        ri = -eq;
        rq = ei;
      end
      2'd2: begin
        ri = -ei;
        rq = -eq;
      end
      default: begin
        ri = eq;
        rq = -ei;
      end
    endcase
  end

  always_comb begin
    item_d.out_i        = narrow(ri);
    item_d.out_q        = narrow(rq);
    item_d.out_line_end = prod_i.line_end;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

// File: rtl/color_under_quadrature_mixer.sv
// Channel  Handshake                      Payload
// in       in_valid_i / in_ready_o        in_item_i  (in_item_t)
// out      out_valid_o / out_ready_i      out_item_o (out_item_t)
// cfg      cfg_we_i                       cfg_wdata_i (phase_step)
//
// One item per cycle while out_ready_i stays high; an accepted item passes through the
// input, product and result registers before it is on the output.
// The phase accumulator of the item's direction is read and advanced at accept.
// Reset clears both accumulators, loads the default phase step, empties the pipe.
// With out_ready_i low the pipe fills and holds; up to three items are in flight.
module color_under_quadrature_mixer import cuqm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_item_o,
  input  logic                 cfg_we_i,
  input  logic [PhaseBits-1:0] cfg_wdata_i
);

  logic                 v1_q, v2_q, v3_q;
  logic                 adv1, adv2, adv3;
  logic                 take;
  logic [TableBits-1:0] index;
  logic [TableBits-1:0] s1_index_q;
  in_item_t             s1_item_q;
  prod_t                prod;

  // A stage may load when it is empty or its item moves on
  assign adv3       = !v3_q || out_ready_i;
  assign adv2       = !v2_q || adv3;
  assign adv1       = !v1_q || adv2;
  assign in_ready_o = adv1;
  assign take       = in_valid_i && adv1;

  cuqm_nco u_nco (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .take_i      (take),
    .op_i        (in_item_i.opcode),
    .index_o     (index)
  );

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_item_q  <= in_item_i;
      s1_index_q <= index;
    end
  end

  cuqm_mix u_mix (
    .clk_i   (clk_i),
    .load_i  (v1_q && adv2),
    .item_i  (s1_item_q),
    .index_i (s1_index_q),
    .prod_o  (prod)
  );

  cuqm_narrow u_narrow (
    .clk_i  (clk_i),
    .load_i (v2_q && adv3),
    .prod_i (prod),
    .item_o (out_item_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) begin
        v1_q <= in_valid_i;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
      if (adv3) begin
        v3_q <= v2_q;
      end
    end
  end

  assign out_valid_o = v3_q;

endmodule

// File: tb/color_under_quadrature_mixer_test.sv
module color_under_quadrature_mixer_test;
  import cuqm_pkg::*;

  localparam int unsigned          NumPhase  = 1 << 10;
  localparam longint unsigned      OneQ30    = 64'd1073741824;
  localparam longint unsigned      TurnQ30   = 64'd6746518852;
  localparam logic [PhaseBits-1:0] EighthTurn = 32'h2000_0000;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;
  logic                 cfg_we_i    = 1'b0;
  logic [PhaseBits-1:0] cfg_wdata_i = '0;

  color_under_quadrature_mixer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Predictor state
  int                   osc_cos[NumPhase];
  int                   osc_sin[NumPhase];
  logic [PhaseBits-1:0] step_q   = PhaseStepReset;
  logic [PhaseBits-1:0] down_acc = '0;
  logic [PhaseBits-1:0] up_acc   = '0;

  in_item_t  samples_q[$];
  out_item_t mixed_q[$];
  int        mismatch_cnt = 0;

  int gap_left   = 0;
  int burst_left = 0;
  int rx_mode    = 0;
  int rx_left    = 0;
  int rx_tick    = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("FAIL color_under_quadrature_mixer");
    $finish;
  end

  function automatic int unsigned to_q15(longint unsigned v);
    longint unsigned r;
    r = (v + 64'd16384) >> 15;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return int'(r);
  endfunction

  // Oscillator entry n: quadrant split, Taylor series on the residual
  function automatic void osc_entry(int unsigned n, output int co, output int si);
    logic [31:0]     ang;
    logic [31:0]     ap;
    longint          sres;
    longint unsigned mag;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    int              c;
    int              s;
    ang  = 32'((64'(n) << 32) / NumPhase);
    ap   = ang + EighthTurn;
    sres = longint'({34'd0, ap[29:0]}) - 64'sh2000_0000;
    mag  = (sres < 0) ? longint'(-sres) : longint'(sres);
    x    = (mag * TurnQ30) >> 32;
    x2   = (x * x) >> 30;
    t = OneQ30 - x2 / 72;
    t = OneQ30 - ((x2 * t) >> 30) / 42;
    t = OneQ30 - ((x2 * t) >> 30) / 20;
    t = OneQ30 - ((x2 * t) >> 30) / 6;
    s = to_q15((x * t) >> 30);
    if (sres < 0) begin
      s = -s;
    end
    t = OneQ30 - x2 / 90;
    t = OneQ30 - ((x2 * t) >> 30) / 56;
    t = OneQ30 - ((x2 * t) >> 30) / 30;
    t = OneQ30 - ((x2 * t) >> 30) / 12;
    t = OneQ30 - ((x2 * t) >> 30) / 2;
    c = to_q15(t);
    case (ap[31:30])
      2'd0: begin co = c;  si = s;  end
      2'd1: begin co = -s; si = c;  end
      2'd2: begin co = -c; si = -s; end
      default: begin co = s; si = -c; end
    endcase
  endfunction

  function automatic void quarter_turn(inout longint x, inout longint y, input logic [1:0] k);
    longint a;
    longint b;
    a = x;
    b = y;
    case (k)
      2'd0: ;
      2'd1: begin x = -b; y = a;  end
      2'd2: begin x = -a; y = -b; end
      default: begin x = b; y = -a; end
    endcase
  endfunction

  function automatic logic signed [SampleBits-1:0] round_sat(longint v);
    longint r;
    r = (v + 64'sd16384) >>> 15;
    if (r > 64'sd32767) begin
      r = 64'sd32767;
    end else if (r < -64'sd32768) begin
      r = -64'sd32768;
    end
    return r[SampleBits-1:0];
  endfunction

  // Mix one sample and advance the accumulator of its direction
  function automatic out_item_t mix_sample(in_item_t it);
    out_item_t   res;
    longint      xi;
    longint      xq;
    longint      yi;
    longint      yq;
    longint      c;
    longint      s;
    logic [1:0]  k;
    logic [9:0]  n;
    xi = longint'($signed(it.in_i));
    xq = longint'($signed(it.in_q));
    k  = it.line_number[2:1];
    if (it.opcode == OpDown) begin
      n = down_acc[31:22];
      down_acc = down_acc + step_q;
    end else begin
      n = up_acc[31:22];
      up_acc = up_acc + step_q;
    end
    c = osc_cos[n];
    s = osc_sin[n];
    if (it.opcode == OpDown) begin
      quarter_turn(xi, xq, k);
      yi = xi * c + xq * s;
      yq = -xi * s + xq * c;
    end else begin
      yi = xi * c - xq * s;
      yq = xi * s + xq * c;
      quarter_turn(yi, yq, 2'(3'd4 - {1'b0, k}));
    end
    res.out_i        = round_sat(yi);
    res.out_q        = round_sat(yq);
    res.out_line_end = it.line_end;
    return res;
  endfunction

  function automatic in_item_t make_item(op_e op, logic [15:0] i, logic [15:0] q,
                                         logic [9:0] line, logic le);
    in_item_t it;
    it.opcode      = op;
    it.in_i        = i;
    it.in_q        = q;
    it.line_number = line;
    it.line_end    = le;
    return it;
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 11))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic in_item_t random_item();
    op_e op;
    op = ($urandom_range(0, 1) == 0) ? OpDown : OpUp;
    return make_item(op, pick_sample(), pick_sample(), 10'($urandom_range(0, 1023)),
                     $urandom_range(0, 7) == 0);
  endfunction

  // Sender: bursts of random length with random gaps
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (samples_q.size() > 0) begin
        in_valid_i <= 1'b1;
        in_item_i  <= samples_q.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern switches between modes
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 300);
    end else begin
      rx_left--;
    end
    rx_tick++;
    case (rx_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 1) == 1);
      2: out_ready_i <= (rx_tick % 5) != 0;
      default: out_ready_i <= (rx_tick % 16) < 3;
    endcase
  end

  // Predict on accept, check on result
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        step_q = cfg_wdata_i;
      end
      if (in_valid_i && in_ready_o) begin
        mixed_q.push_back(mix_sample(in_item_i));
      end
      if (out_valid_o && out_ready_i) begin
        if (mixed_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("unexpected item: i=%0d q=%0d le=%0b", $signed(out_item_o.out_i),
                     $signed(out_item_o.out_q), out_item_o.out_line_end);
          end
        end else begin
          want = mixed_q.pop_front();
          if (want.out_i !== out_item_o.out_i || want.out_q !== out_item_o.out_q ||
              want.out_line_end !== out_item_o.out_line_end) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("mismatch: expected i=%0d q=%0d le=%0b, got i=%0d q=%0d le=%0b",
                       $signed(want.out_i), $signed(want.out_q), want.out_line_end,
                       $signed(out_item_o.out_i), $signed(out_item_o.out_q),
                       out_item_o.out_line_end);
            end
          end
        end
      end
    end
  end

  task automatic wait_idle();
    while (samples_q.size() != 0 || in_valid_i || mixed_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (6) @(posedge clk_i);
  endtask

  task automatic set_step(logic [PhaseBits-1:0] v);
    wait_idle();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    logic [PhaseBits-1:0] steps[6];
    int c;
    int s;
    for (int n = 0; n < NumPhase; n++) begin
      osc_entry(n, c, s);
      osc_cos[n] = c;
      osc_sin[n] = s;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Default step: every quarter-turn, both directions, extreme samples
    for (int k = 0; k < 4; k++) begin
      samples_q.push_back(make_item(OpDown, 16'h7FFF, 16'h8000, 10'(2 * k), 1'b0));
      samples_q.push_back(make_item(OpUp, 16'h8000, 16'h7FFF, 10'(2 * k + 8), 1'b1));
    end
    samples_q.push_back(make_item(OpDown, 16'h0000, 16'h0000, 10'd1023, 1'b1));
    samples_q.push_back(make_item(OpUp, 16'hFFFF, 16'hFFFF, 10'd1, 1'b0));
    samples_q.push_back(make_item(OpDown, 16'h8000, 16'h8000, 10'd1022, 1'b0));
    samples_q.push_back(make_item(OpUp, 16'h7FFF, 16'h7FFF, 10'd1021, 1'b1));

    // Eighth-turn step moves the phase 45 degrees per item: full-scale inputs saturate
    set_step(EighthTurn);
    for (int j = 0; j < 4; j++) begin
      samples_q.push_back(make_item(OpDown, 16'h8000, 16'h8000, 10'd0, 1'b0));
      samples_q.push_back(make_item(OpUp, 16'h7FFF, 16'h7FFF, 10'd0, 1'b1));
    end

    steps[0] = 32'hFFFF_FFFF;
    steps[1] = 32'h0000_0000;
    steps[2] = $urandom();
    steps[3] = $urandom_range(1, 4000);
    steps[4] = 32'h8000_0000;
    steps[5] = $urandom();
    foreach (steps[p]) begin
      set_step(steps[p]);
      for (int j = 0; j < 275; j++) begin
        samples_q.push_back(random_item());
      end
    end

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0 && mixed_q.size() == 0) begin
      $display("PASS color_under_quadrature_mixer");
    end else begin
      $display("FAIL color_under_quadrature_mixer");
    end
    $finish;
  end

endmodule
